[hdl/oaat_pkg.sv]
// shared types and constants for the one-at-a-time hash slot index block
// no dependencies
`default_nettype none

package oaat_pkg;

	localparam int AccW      = 64;
	localparam int ByteW     = 8;
	localparam int SizeW     = 21;
	localparam int SlotW     = 20;
	localparam int DivSteps  = AccW;
	localparam int CntW      = $clog2(DivSteps);

	localparam logic [SizeW-1:0] SizeReset = SizeW'(1024);
	localparam logic [SizeW-1:0] SizeMax   = SizeW'(1048576);
	localparam logic [SizeW-1:0] SizeMin   = SizeW'(1);

	localparam int MixShl   = 10;
	localparam int MixShr   = 6;
	localparam int FinShl1  = 3;
	localparam int FinShr   = 11;
	localparam int FinShl2  = 15;

	typedef struct packed {
		logic load_in;
		logic mix;
		logic fin1;
		logic fin2;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic div_last;
	} status_t;

endpackage

`default_nettype wire

[hdl/oaat_ctrl.sv]
// controller state machine for the one-at-a-time hash slot index block
// depends on oaat_pkg; drives oaat_dp through cmd_t and reads status_t
`default_nettype none

module oaat_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output oaat_pkg::cmd_t         cmd,
	input  wire oaat_pkg::status_t status
);
	import oaat_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MIX,
		S_FIN1,
		S_FIN2,
		S_DIV,
		S_PUSH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load_in  = in_valid && (state_q == S_IDLE);
		cmd.mix      = (state_q == S_MIX);
		cmd.fin1     = (state_q == S_FIN1);
		cmd.fin2     = (state_q == S_FIN2);
		cmd.div_step = (state_q == S_DIV);
		cmd.load_out = (state_q == S_PUSH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_PUSH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MIX;
					end
				end
				S_MIX: begin
					state_q <= status.last ? S_FIN1 : S_IDLE;
				end
				S_FIN1: begin
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (status.div_last) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/oaat_dp.sv]
// datapath: hash accumulator, mixing steps, table size register and
// bit-serial restoring divider for the slot index; depends on oaat_pkg
`default_nettype none

module oaat_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [oaat_pkg::SizeW-1:0]   cfg_wr_data,
	input  wire logic [oaat_pkg::ByteW-1:0]   char_byte,
	input  wire logic                         last_char,
	input  wire oaat_pkg::cmd_t               cmd,
	output oaat_pkg::status_t                 status,
	output logic      [oaat_pkg::SlotW-1:0]   slot_index
);
	import oaat_pkg::*;

	logic [AccW-1:0]  acc_q;
	logic [SizeW-1:0] table_size_q;
	logic [CntW-1:0]  cnt_q;
	logic             last_q;
	logic [AccW-1:0]  num_q;
	logic [SlotW-1:0] rem_q;
	logic [SizeW-1:0] div_q;
	logic [SlotW-1:0] slot_q;

	logic [AccW-1:0]  byte_ext;
	logic [AccW-1:0]  mix_sum;
	logic [AccW-1:0]  fin1_sum;
	logic [AccW-1:0]  fin2_sum;
	logic [SizeW-1:0] eff_size;
	logic [SizeW-1:0] rem_shift;
	logic [SlotW-1:0] rem_diff;

	assign byte_ext = {{(AccW-ByteW){char_byte[ByteW-1]}}, char_byte};
	assign mix_sum  = acc_q + (acc_q << MixShl);
	assign fin1_sum = acc_q + (acc_q << FinShl1);
	assign fin2_sum = acc_q + (acc_q << FinShl2);

	always_comb begin
		if (table_size_q == '0) begin
			eff_size = SizeMin;
		end else if (table_size_q > SizeMax) begin
			eff_size = SizeMax;
		end else begin
			eff_size = table_size_q;
		end
	end

	assign rem_shift = {rem_q, num_q[AccW-1]};
	assign rem_diff  = SlotW'(rem_shift - div_q);

	assign status.last     = last_q;
	assign status.div_last = (cnt_q == CntW'(DivSteps-1));
	assign slot_index      = slot_q;

	// control state and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			table_size_q <= SizeReset;
			cnt_q        <= '0;
		end else begin
			if (cfg_wr_en) begin
				table_size_q <= cfg_wr_data;
			end
			if (cmd.load_in) begin
				acc_q <= acc_q + byte_ext;
			end else if (cmd.mix) begin
				acc_q <= mix_sum ^ (mix_sum >> MixShr);
			end else if (cmd.fin1) begin
				acc_q <= fin1_sum ^ (fin1_sum >> FinShr);
			end else if (cmd.fin2) begin
				acc_q <= '0;
			end
			if (cmd.fin2) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CntW'(1);
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			last_q <= last_char;
		end
		if (cmd.fin2) begin
			num_q <= fin2_sum;
			rem_q <= '0;
			div_q <= eff_size;
		end else if (cmd.div_step) begin
			num_q <= num_q << 1;
			if (rem_shift >= div_q) begin
				rem_q <= rem_diff;
			end else begin
				rem_q <= rem_shift[SlotW-1:0];
			end
		end
		if (cmd.load_out) begin
			slot_q <= rem_q;
		end
	end

endmodule

`default_nettype wire

[hdl/one_at_a_time_hash_index.sv]
// One-at-a-time hash slot index. Each request carries one byte of a name
// and a flag on its last byte; each byte enters the accumulator as a
// sign-extended add, then a shift-add and xor. After the last byte the
// final mix is applied and a bit-serial divider reduces the 64-bit hash
// modulo table_size, one quotient bit per cycle. The result sits in an
// output register, so the next name is taken while it waits. table_size
// 0 acts as 1, values above 1048576 act as 1048576; write it only while
// the block is idle.
// depends on oaat_pkg, oaat_ctrl and oaat_dp
`default_nettype none

module one_at_a_time_hash_index (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [oaat_pkg::SizeW-1:0] cfg_wr_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [oaat_pkg::ByteW-1:0] char_byte,
	input  wire logic                       last_char,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic      [oaat_pkg::SlotW-1:0] slot_index
);
	import oaat_pkg::*;

	cmd_t    cmd;
	status_t status;

	oaat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	oaat_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.char_byte   (char_byte),
		.last_char   (last_char),
		.cmd         (cmd),
		.status      (status),
		.slot_index  (slot_index)
	);

endmodule

`default_nettype wire
